[hdl/pcte_pkg.sv]
// ----------------------------------------------------------------------------
// pcte_pkg: shared types and constants
// Widths, opcodes, status codes and digit helpers of the trie engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pcte_pkg;

  localparam int POOL_NODES = 1024;
  localparam int KEY_DIGITS = 16;
  localparam int VALUE_BITS = 16;

  localparam int KEY_BITS   = 4 * KEY_DIGITS;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int FREE_W     = NODE_W + 1;
  localparam int FANOUT_W   = 8;
  localparam int ADDR_W     = NODE_W + FANOUT_W;
  localparam int ENTRY_W    = (VALUE_BITS > NODE_W) ? VALUE_BITS : NODE_W;
  localparam int PDIG_W     = 4;
  localparam int PBITS_W    = KEY_BITS - 4;
  localparam int CNT_W      = 5;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic                start;
    logic [KEY_BITS-1:0] key;
    logic [KEY_BITS-1:0] high;
  } pfx_req_t;

  typedef struct packed {
    logic               done;
    logic [PDIG_W-1:0]  digits;
    logic [PBITS_W-1:0] bits;
  } pfx_rsp_t;

  // two digits starting at digit position pos
  function automatic logic [7:0] key_pair(input logic [KEY_BITS-1:0] k,
                                          input logic [CNT_W-1:0] pos);
    logic [KEY_BITS-1:0] t;
    t = k >> {pos, 2'b00};
    return t[7:0];
  endfunction

  function automatic logic [3:0] key_digit(input logic [KEY_BITS-1:0] k,
                                           input logic [CNT_W-1:0] pos);
    logic [KEY_BITS-1:0] t;
    t = k >> {pos, 2'b00};
    return t[3:0];
  endfunction

endpackage
`default_nettype wire

[hdl/prefix_compressed_trie_engine_core.sv]
// ----------------------------------------------------------------------------
// prefix_compressed_trie_engine_core: prefix-compressed multibit trie
// Begin, insert, find and clear over a node pool held in one memory.
// ----------------------------------------------------------------------------
// Steps: clear resets the trie registers; find walks one level per
//   node read (at most 8 levels); begin runs the prefix search, then
//   empties the root; insert walks the levels and empties every node it
//   allocates, one entry per cycle through the single memory write port.
// Throughput: one beat at a time; in_ready only in the idle state.
// Reset: control and trie registers clear; node memory is not cleared,
//   each node is emptied when allocated.
// ----------------------------------------------------------------------------
`default_nettype none
module prefix_compressed_trie_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [63:0] in_key,
  input  wire logic [63:0] in_high_key,
  input  wire logic [15:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_found_value
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SET  = 3'd1;
  localparam logic [2:0] S_PFX  = 3'd2;
  localparam logic [2:0] S_CLR  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam int KB = pcte_pkg::KEY_BITS;
  localparam int NW = pcte_pkg::NODE_W;
  localparam int EW = pcte_pkg::ENTRY_W;
  localparam int VB = pcte_pkg::VALUE_BITS;
  localparam int CW = pcte_pkg::CNT_W;

  logic [2:0] state_r, state_nxt;

  // latched beat
  logic [1:0]    op_r;
  logic [KB-1:0] key_r, high_r;
  logic [VB-1:0] val_r;

  // trie state
  logic                         present_r, present_nxt;
  logic [pcte_pkg::PDIG_W-1:0]  pdig_r, pdig_nxt;
  logic [pcte_pkg::PBITS_W-1:0] pbits_r, pbits_nxt;
  logic [pcte_pkg::FREE_W-1:0]  free_r, free_nxt;

  // walk state
  logic [NW-1:0] node_r, node_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [CW-1:0] f_r, f_nxt;
  logic [NW-1:0] clr_node_r, clr_node_nxt;
  logic [7:0]    clr_cnt_r, clr_cnt_nxt;
  logic          clr_begin_r, clr_begin_nxt;

  // result
  logic [1:0]    res_st_r, res_st_nxt;
  logic [VB-1:0] res_val_r, res_val_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [VB-1:0] out_val_r, out_val_nxt;

  // node memory
  logic [EW-1:0]                   node_mem [0:(1 << pcte_pkg::ADDR_W)-1];
  logic                            mem_we;
  logic [pcte_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [EW-1:0]                   mem_wdata, rd_data_r;

  pcte_pkg::pfx_req_t pfx_req;
  pcte_pkg::pfx_rsp_t pfx_rsp;

  logic          accept;
  logic [CW-1:0] f_free;
  logic [KB-1:0] key_hi;
  logic [VB-1:0] leaf_val;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign f_free   = CW'(pcte_pkg::KEY_DIGITS) - CW'(pdig_r);
  assign key_hi   = key_r >> {f_free, 2'b00};
  assign leaf_val = rd_data_r[VB-1:0];

  assign pfx_req.start = (state_r == S_SET) && (op_r == pcte_pkg::OP_BEGIN);
  assign pfx_req.key   = key_r;
  assign pfx_req.high  = high_r;

  pcte_prefix_unit u_pfx (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pfx_req),
    .rsp   (pfx_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    pdig_nxt      = pdig_r;
    pbits_nxt     = pbits_r;
    free_nxt      = free_r;
    node_nxt      = node_r;
    idx_nxt       = idx_r;
    f_nxt         = f_r;
    clr_node_nxt  = clr_node_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_begin_nxt = clr_begin_r;
    res_st_nxt    = res_st_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_st_nxt    = out_st_r;
    out_val_nxt   = out_val_r;
    mem_we        = 1'b0;
    mem_waddr     = {node_r, idx_r};
    mem_wdata     = '0;
    mem_raddr     = {node_r, idx_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_SET;
          res_st_nxt  = pcte_pkg::ST_OK;
          res_val_nxt = '0;
        end
      end
      S_SET: begin
        case (op_r)
          pcte_pkg::OP_BEGIN: begin
            state_nxt = S_PFX;
          end
          pcte_pkg::OP_CLEAR: begin
            present_nxt = 1'b0;
            pdig_nxt    = '0;
            pbits_nxt   = '0;
            free_nxt    = '0;
            state_nxt   = S_DONE;
          end
          default: begin
            if (!present_r) begin
              res_st_nxt = pcte_pkg::ST_NONE;
              state_nxt  = S_DONE;
            end else if (op_r == pcte_pkg::OP_FIND &&
                         key_hi != KB'(pbits_r)) begin
              res_st_nxt = pcte_pkg::ST_MISS;
              state_nxt  = S_DONE;
            end else begin
              node_nxt  = '0;
              state_nxt = S_RD;
              // odd free digit count: root takes one digit only
              if (f_free[0]) begin
                idx_nxt = {4'b0, pcte_pkg::key_digit(key_r, f_free - CW'(1))};
                f_nxt   = f_free + CW'(1);
              end else begin
                idx_nxt = pcte_pkg::key_pair(key_r, f_free - CW'(2));
                f_nxt   = f_free;
              end
            end
          end
        endcase
      end
      S_PFX: begin
        if (pfx_rsp.done) begin
          pdig_nxt      = pfx_rsp.digits;
          pbits_nxt     = pfx_rsp.bits;
          free_nxt      = pcte_pkg::FREE_W'(1);
          present_nxt   = 1'b1;
          clr_node_nxt  = '0;
          clr_cnt_nxt   = '0;
          clr_begin_nxt = 1'b1;
          state_nxt     = S_CLR;
        end
      end
      S_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = {clr_node_r, clr_cnt_r};
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 8'd1;
        if (clr_cnt_r == 8'hff) begin
          state_nxt = clr_begin_r ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        if (f_r == CW'(2) && op_r == pcte_pkg::OP_INSERT) begin
          mem_we    = 1'b1;
          mem_wdata = EW'(VB'(val_r + VB'(1)));
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (f_r == CW'(2)) begin
          // leaf of a find; zero means empty
          state_nxt = S_DONE;
          if (leaf_val == '0) begin
            res_st_nxt = pcte_pkg::ST_MISS;
          end else begin
            res_val_nxt = leaf_val - VB'(1);
          end
        end else if (rd_data_r == '0) begin
          if (op_r == pcte_pkg::OP_FIND) begin
            res_st_nxt = pcte_pkg::ST_MISS;
            state_nxt  = S_DONE;
          end else if (free_r == pcte_pkg::FREE_W'(pcte_pkg::POOL_NODES)) begin
            res_st_nxt = pcte_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            mem_we        = 1'b1;
            mem_wdata     = EW'(free_r[NW-1:0]);
            node_nxt      = free_r[NW-1:0];
            clr_node_nxt  = free_r[NW-1:0];
            clr_cnt_nxt   = '0;
            clr_begin_nxt = 1'b0;
            free_nxt      = free_r + pcte_pkg::FREE_W'(1);
            f_nxt         = f_r - CW'(2);
            idx_nxt       = pcte_pkg::key_pair(key_r, f_r - CW'(4));
            state_nxt     = S_CLR;
          end
        end else begin
          node_nxt  = rd_data_r[NW-1:0];
          f_nxt     = f_r - CW'(2);
          idx_nxt   = pcte_pkg::key_pair(key_r, f_r - CW'(4));
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_val_nxt   = res_val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= 1'b0;
      pdig_r      <= '0;
      pbits_r     <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      pdig_r      <= pdig_nxt;
      pbits_r     <= pbits_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      op_r   <= in_op;
      key_r  <= KB'(in_key);
      high_r <= KB'(in_high_key);
      val_r  <= VB'(in_value);
    end
    node_r      <= node_nxt;
    idx_r       <= idx_nxt;
    f_r         <= f_nxt;
    clr_node_r  <= clr_node_nxt;
    clr_cnt_r   <= clr_cnt_nxt;
    clr_begin_r <= clr_begin_nxt;
    res_st_r    <= res_st_nxt;
    res_val_r   <= res_val_nxt;
    out_st_r    <= out_st_nxt;
    out_val_r   <= out_val_nxt;
  end

  // node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= node_mem[mem_raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_found_value = 16'(out_val_r);

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= pcte_pkg::FREE_W'(pcte_pkg::POOL_NODES))
    else $error("free node count past pool size");

  a_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
    !present_r |-> free_r == '0)
    else $error("nodes held with no trie");

  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_st_r == pcte_pkg::ST_FULL) |->
      op_r == pcte_pkg::OP_INSERT)
    else $error("pool full reported for non-insert");

  a_val_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_val_r != '0) |-> out_st_r == pcte_pkg::ST_OK)
    else $error("value returned with failing status");

  a_clr_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && clr_cnt_r != 8'hff) |=> state_r == S_CLR)
    else $error("node emptying cut short");

endmodule
`default_nettype wire

[hdl/pcte_prefix_unit.sv]
// ----------------------------------------------------------------------------
// pcte_prefix_unit: common prefix search
// Shifts key and key-xor-high right one digit a cycle until the xor is gone.
// ----------------------------------------------------------------------------
`default_nettype none
module pcte_prefix_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  pcte_pkg::pfx_req_t     req,
  output pcte_pkg::pfx_rsp_t     rsp
);

  logic                          busy_r, busy_nxt;
  logic [pcte_pkg::KEY_BITS-1:0] diff_r, diff_nxt;
  logic [pcte_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [pcte_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [pcte_pkg::CNT_W-1:0]    digs;

  always_comb begin
    busy_nxt = busy_r;
    diff_nxt = diff_r;
    key_nxt  = key_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      diff_nxt = (req.key ^ req.high) >> 4;
      key_nxt  = req.key >> 4;
      cnt_nxt  = pcte_pkg::CNT_W'(1);
    end else if (busy_r) begin
      if (diff_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        diff_nxt = diff_r >> 4;
        key_nxt  = key_r >> 4;
        cnt_nxt  = cnt_r + pcte_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    diff_r <= diff_nxt;
    key_r  <= key_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign digs       = pcte_pkg::CNT_W'(pcte_pkg::KEY_DIGITS) - cnt_r;
  assign rsp.done   = busy_r && (diff_r == '0);
  assign rsp.digits = digs[pcte_pkg::PDIG_W-1:0];
  assign rsp.bits   = key_r[pcte_pkg::PBITS_W-1:0];

endmodule
`default_nettype wire
